FILE: rtl/aelt_pkg.sv
package aelt_pkg;

    localparam int PIX_W      = 8;
    localparam int HW_W       = 3;
    localparam int ALPHA_W    = 7;
    localparam int IMGW_W     = 11;
    localparam int IMGH_W     = 13;
    localparam int CX_W       = 10;
    localparam int CY_W       = 12;
    localparam int CFG_DATA_W = 13;

    localparam int DEF_MAX_WIDTH       = 1024;
    localparam int DEF_MAX_HALF_WINDOW = 5;
    localparam int MAX_HEIGHT          = 4096;

    localparam logic [HW_W-1:0]    RST_HALF_WINDOW = 3'd3;
    localparam logic [ALPHA_W-1:0] RST_ALPHA       = 7'd67;
    localparam logic [IMGW_W-1:0]  RST_WIDTH       = 11'd640;
    localparam logic [IMGH_W-1:0]  RST_HEIGHT      = 13'd480;

    typedef enum logic [1:0] {
        CFG_HALF_WINDOW = 2'd0,
        CFG_ALPHA       = 2'd1,
        CFG_WIDTH       = 2'd2,
        CFG_HEIGHT      = 2'd3
    } cfg_index_t;

    // per-cycle control broadcast along the cell row
    typedef struct packed {
        logic hshift;
        logic step;
        logic sshift;
        logic m0;
        logic m1;
        logic m2;
        logic mc;
    } cell_ctl_t;

    // control of the horizontal window accumulator
    typedef struct packed {
        logic clr;
        logic step;
        logic h0;
        logic h1;
        logic h2;
        logic hc;
    } acc_ctl_t;

    // {center, 2..2k+2, 1..2k+1, 0..2k} membership of an offset
    function automatic logic [3:0] age_mask(input int age, input int k);
        logic [3:0] m;
        m[0] = (age <= 2 * k);
        m[1] = (age >= 1) && (age <= 2 * k + 1);
        m[2] = (age >= 2) && (age <= 2 * k + 2);
        m[3] = (age == k + 1);
        return m;
    endfunction

endpackage

FILE: rtl/adaptive_eight_landmark_threshold_unit.sv
// Adaptive threshold, eight landmarks. Gray pixels enter in raster order on the
// input channel (in_valid / in_stall / gray_pixel); a transaction is taken when
// in_valid is high and in_stall low. Each interior center pixel gets one result
// transaction (is_background, center_x, center_y, frame_end) on the output
// channel, issued when the pixel K+1 columns right and K+1 rows below arrives.
// One pixel is processed at a time: no new pixel is taken until the block is
// through with the last one, and a pixel that yields a decision occupies the
// block longer (ROWS = 2*MAX_HALF_WINDOW+3, 13 by default). The time taken is
// set by the single read port of the line store, read once per stored row to
// load one column into the cell row, and by the serial pass over the cells that
// adds up the window sums. A result sits in the output register until taken;
// while out_stall holds it there the next pixel is still accepted and processed,
// and the block waits only when it has a second result to hand over.
// Reset clears column and row counters and the output valid flag, and sets
// the registers to K=3, alpha=0.67, 640x480. Line store contents are not cleared.
// Registers are written through cfg_write / cfg_index / cfg_data between frames
// or while the block is idle.
module adaptive_eight_landmark_threshold_unit #(
    parameter int MAX_WIDTH       = aelt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HALF_WINDOW = aelt_pkg::DEF_MAX_HALF_WINDOW
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  aelt_pkg::cfg_index_t            cfg_index,
    input  logic [aelt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [aelt_pkg::PIX_W-1:0]      gray_pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            is_background,
    output logic [aelt_pkg::CX_W-1:0]       center_x,
    output logic [aelt_pkg::CY_W-1:0]       center_y,
    output logic                            frame_end
);
    import aelt_pkg::*;

    localparam int ROWS = 2 * MAX_HALF_WINDOW + 3;
    localparam int RW   = $clog2(ROWS);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = (CW + 1 > IMGW_W) ? CW + 1 : IMGW_W;
    localparam int VSW  = $clog2((2 * MAX_HALF_WINDOW + 1) * 255 + 1);
    localparam int WSW  = $clog2((2 * MAX_HALF_WINDOW + 1) * (2 * MAX_HALF_WINDOW + 1)
                                 * 255 + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_SETTLE = 6'b000100,
        ST_EVAL   = 6'b001000,
        ST_CALC   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [HW_W-1:0]    hw_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [IMGW_W-1:0]  width_reg;
    logic [IMGH_W-1:0]  height_reg;

    logic [CW-1:0]   col_reg, col_next;
    logic [CY_W-1:0] row_reg, row_next;
    logic [RW-1:0]   ring_reg, ring_next;

    logic [CW-1:0]   col_item_reg;
    logic [RW-1:0]   ring_item_reg;
    logic            decide_reg;
    logic [CX_W-1:0] x_reg;
    logic [CY_W-1:0] y_reg;
    logic            fe_reg;

    logic [RW-1:0]   age_reg, age_next;
    logic            rd_valid_reg;
    logic [RW-1:0]   rd_age_reg;
    logic [1:0]      calc_reg, calc_next;

    logic                out_valid_reg;
    logic                bg_out_reg;
    logic [CX_W-1:0]     cx_out_reg;
    logic [CY_W-1:0]     cy_out_reg;
    logic                fe_out_reg;

    logic              in_accept, out_accept, out_load;
    logic [HW_W-1:0]   k_eff;
    logic [EW-1:0]     w_eff, col_x, c2;
    logic [IMGH_W-1:0] h_eff, r1, r2;
    logic              wrap_c, wrap_r, end_row, end_frame;
    logic [CW-1:0]     c_eff;
    logic [CY_W-1:0]   r_eff;
    logic [RW-1:0]     ring1, ring_eff;
    logic [4:0]        thr;
    logic              decide;
    logic [RW:0]       rd_sum;
    logic [RW-1:0]     rd_row;
    logic [PIX_W-1:0]  rd_data;
    logic [3:0]        rmask, hmask;

    cell_ctl_t cell_ctl;
    acc_ctl_t  acc_ctl;
    logic      background;

    logic [ROWS*PIX_W-1:0] col_bus  [ROWS];
    logic [VSW-1:0]        vs0_bus  [ROWS];
    logic [VSW-1:0]        vs1_bus  [ROWS];
    logic [VSW-1:0]        vs2_bus  [ROWS];
    logic [PIX_W-1:0]      vmin_bus [ROWS];
    logic [PIX_W-1:0]      vmax_bus [ROWS];
    logic [PIX_W-1:0]      pc_bus   [ROWS];

    function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] r);
        return (r == RW'(ROWS - 1)) ? '0 : r + 1'b1;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg     <= RST_HALF_WINDOW;
            alpha_reg  <= RST_ALPHA;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HALF_WINDOW: hw_reg     <= cfg_data[HW_W-1:0];
                CFG_ALPHA:       alpha_reg  <= cfg_data[ALPHA_W-1:0];
                CFG_WIDTH:       width_reg  <= cfg_data[IMGW_W-1:0];
                CFG_HEIGHT:      height_reg <= cfg_data[IMGH_W-1:0];
                default:         hw_reg     <= hw_reg;
            endcase
        end
    end

    // clamped settings
    always_comb
    begin
        priority if (hw_reg == '0)
            k_eff = HW_W'(1);
        else if (hw_reg > HW_W'(MAX_HALF_WINDOW))
            k_eff = HW_W'(MAX_HALF_WINDOW);
        else
            k_eff = hw_reg;

        priority if (width_reg == '0)
            w_eff = EW'(1);
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = EW'(width_reg);

        priority if (height_reg == '0)
            h_eff = IMGH_W'(1);
        else if (height_reg > IMGH_W'(MAX_HEIGHT))
            h_eff = IMGH_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // raster position of the incoming pixel and of the one after it
    always_comb
    begin
        col_x    = EW'(col_reg);
        wrap_c   = (col_x >= w_eff);
        c_eff    = wrap_c ? '0 : col_reg;
        r1       = IMGH_W'(row_reg) + IMGH_W'(wrap_c);
        wrap_r   = (r1 >= h_eff);
        r_eff    = wrap_r ? '0 : r1[CY_W-1:0];
        ring1    = wrap_c ? ring_inc(ring_reg) : ring_reg;
        ring_eff = wrap_r ? '0 : ring1;

        c2        = EW'(c_eff) + EW'(1);
        r2        = IMGH_W'(r_eff) + IMGH_W'(1);
        end_row   = (c2 >= w_eff);
        end_frame = end_row && (r2 >= h_eff);
        col_next  = end_row ? '0 : c2[CW-1:0];
        row_next  = end_frame ? '0 : (end_row ? r2[CY_W-1:0] : r_eff);
        ring_next = end_frame ? '0 : (end_row ? ring_inc(ring_eff) : ring_eff);

        thr    = {1'b0, k_eff, 1'b0} + 5'd2;
        decide = (r_eff >= CY_W'(thr)) && (EW'(c_eff) >= EW'(thr));
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ring_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ring_reg <= ring_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decide_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            decide_reg <= decide;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            col_item_reg  <= c_eff;
            ring_item_reg <= ring_eff;
            x_reg  <= CX_W'(c_eff - CW'(k_eff) - CW'(1));
            y_reg  <= r_eff - CY_W'(k_eff) - CY_W'(1);
            fe_reg <= (IMGH_W'(r_eff) == h_eff - IMGH_W'(1))
                   && (EW'(c_eff) == w_eff - EW'(1));
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        age_next   = age_reg;
        calc_next  = calc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_LOAD;
                    age_next   = '0;
                end
            end
            ST_LOAD:
            begin
                if (age_reg == RW'(ROWS - 1))
                begin
                    state_next = ST_SETTLE;
                    age_next   = '0;
                end
                else
                begin
                    age_next = age_reg + 1'b1;
                end
            end
            ST_SETTLE:
            begin
                state_next = decide_reg ? ST_EVAL : ST_IDLE;
            end
            ST_EVAL:
            begin
                if (age_reg == RW'(ROWS - 1))
                begin
                    state_next = ST_CALC;
                    age_next   = '0;
                    calc_next  = '0;
                end
                else
                begin
                    age_next = age_reg + 1'b1;
                end
            end
            ST_CALC:
            begin
                if (calc_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    calc_next = calc_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            age_reg      <= '0;
            calc_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_age_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            age_reg      <= age_next;
            calc_reg     <= calc_next;
            rd_valid_reg <= (state_reg == ST_LOAD);
            rd_age_reg   <= age_reg;
        end
    end

    // row of the ring that is age_reg rows above the current one
    assign rd_sum = {1'b0, ring_item_reg} + (RW+1)'(ROWS) - {1'b0, age_reg};
    assign rd_row = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : RW'(rd_sum);

    aelt_line_store #(
        .ROWS      (ROWS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (in_accept),
        .wrow  (ring_eff),
        .wcol  (c_eff),
        .wdata (gray_pixel),
        .re    (state_reg == ST_LOAD),
        .rrow  (rd_row),
        .rcol  (col_item_reg),
        .rdata (rd_data)
    );

    assign rmask = age_mask(int'(rd_age_reg), int'(k_eff));
    assign hmask = age_mask(ROWS - 1 - int'(age_reg), int'(k_eff));

    always_comb
    begin
        cell_ctl.hshift = in_accept;
        cell_ctl.step   = rd_valid_reg;
        cell_ctl.sshift = (state_reg == ST_EVAL);
        cell_ctl.m0     = rmask[0];
        cell_ctl.m1     = rmask[1];
        cell_ctl.m2     = rmask[2];
        cell_ctl.mc     = rmask[3];

        acc_ctl.clr  = in_accept;
        acc_ctl.step = (state_reg == ST_EVAL);
        acc_ctl.h0   = hmask[0];
        acc_ctl.h1   = hmask[1];
        acc_ctl.h2   = hmask[2];
        acc_ctl.hc   = hmask[3];
    end

    // cell i holds the column i pixels left of the current one
    genvar gi;
    for (gi = 0; gi < ROWS; gi++)
    begin : g_cell
        localparam int PREV = (gi + ROWS - 1) % ROWS;

        aelt_cell #(
            .ROWS  (ROWS),
            .VSW   (VSW),
            .FIRST (gi == 0)
        ) u_cell (
            .clk      (clk),
            .ctl      (cell_ctl),
            .col_in   (col_bus[PREV]),
            .pix_in   (rd_data),
            .vs0_in   (vs0_bus[PREV]),
            .vs1_in   (vs1_bus[PREV]),
            .vs2_in   (vs2_bus[PREV]),
            .vmin_in  (vmin_bus[PREV]),
            .vmax_in  (vmax_bus[PREV]),
            .pc_in    (pc_bus[PREV]),
            .col_out  (col_bus[gi]),
            .vs0_out  (vs0_bus[gi]),
            .vs1_out  (vs1_bus[gi]),
            .vs2_out  (vs2_bus[gi]),
            .vmin_out (vmin_bus[gi]),
            .vmax_out (vmax_bus[gi]),
            .pc_out   (pc_bus[gi])
        );
    end

    aelt_decide #(
        .VSW (VSW),
        .WSW (WSW)
    ) u_decide (
        .clk        (clk),
        .ctl        (acc_ctl),
        .k          (k_eff),
        .alpha      (alpha_reg),
        .vs0        (vs0_bus[ROWS-1]),
        .vs1        (vs1_bus[ROWS-1]),
        .vs2        (vs2_bus[ROWS-1]),
        .vmin       (vmin_bus[ROWS-1]),
        .vmax       (vmax_bus[ROWS-1]),
        .pc         (pc_bus[ROWS-1]),
        .background (background)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            bg_out_reg <= background;
            cx_out_reg <= x_reg;
            cy_out_reg <= y_reg;
            fe_out_reg <= fe_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_background = bg_out_reg;
    assign center_x      = cx_out_reg;
    assign center_y      = cy_out_reg;
    assign frame_end     = fe_out_reg;

    a_accept_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_LOAD))
        else $error("pixel accepted but column load did not start");

    a_step_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_LOAD || state_reg == ST_SETTLE))
        else $error("cell step outside of column load");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE && decide_reg))
        else $error("result issued without a finished decision");

    a_age_range: assert property (@(posedge clk) disable iff (!rst_n)
        age_reg <= RW'(ROWS - 1))
        else $error("row age counter out of range");

endmodule

FILE: rtl/aelt_line_store.sv
module aelt_line_store #(
    parameter int ROWS      = 13,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(ROWS)-1:0]    wrow,
    input  logic [$clog2(MAX_WIDTH)-1:0] wcol,
    input  logic [aelt_pkg::PIX_W-1:0] wdata,
    input  logic                       re,
    input  logic [$clog2(ROWS)-1:0]    rrow,
    input  logic [$clog2(MAX_WIDTH)-1:0] rcol,
    output logic [aelt_pkg::PIX_W-1:0] rdata
);
    import aelt_pkg::*;

    logic [PIX_W-1:0] mem [ROWS][MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wrow][wcol] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[rrow][rcol];
        end
    end

endmodule

FILE: rtl/aelt_cell.sv
module aelt_cell #(
    parameter int ROWS  = 13,
    parameter int VSW   = 12,
    parameter bit FIRST = 1'b0
) (
    input  logic                          clk,
    input  aelt_pkg::cell_ctl_t           ctl,
    input  logic [ROWS*aelt_pkg::PIX_W-1:0] col_in,
    input  logic [aelt_pkg::PIX_W-1:0]    pix_in,
    input  logic [VSW-1:0]                vs0_in,
    input  logic [VSW-1:0]                vs1_in,
    input  logic [VSW-1:0]                vs2_in,
    input  logic [aelt_pkg::PIX_W-1:0]    vmin_in,
    input  logic [aelt_pkg::PIX_W-1:0]    vmax_in,
    input  logic [aelt_pkg::PIX_W-1:0]    pc_in,
    output logic [ROWS*aelt_pkg::PIX_W-1:0] col_out,
    output logic [VSW-1:0]                vs0_out,
    output logic [VSW-1:0]                vs1_out,
    output logic [VSW-1:0]                vs2_out,
    output logic [aelt_pkg::PIX_W-1:0]    vmin_out,
    output logic [aelt_pkg::PIX_W-1:0]    vmax_out,
    output logic [aelt_pkg::PIX_W-1:0]    pc_out
);
    import aelt_pkg::*;

    logic [PIX_W-1:0] col_reg [ROWS];
    logic [PIX_W-1:0] v;
    logic [VSW-1:0]   vs0_reg, vs1_reg, vs2_reg;
    logic [PIX_W-1:0] vmin_reg, vmax_reg, pc_reg;

    // first cell takes the fresh column, the others rotate their own
    assign v = FIRST ? pix_in : col_reg[0];

    genvar gj;
    for (gj = 0; gj < ROWS; gj++)
    begin : g_pack
        assign col_out[gj*PIX_W +: PIX_W] = col_reg[gj];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.hshift)
        begin
            for (int j = 0; j < ROWS; j++)
            begin
                col_reg[j] <= col_in[j*PIX_W +: PIX_W];
            end
        end
        else if (ctl.step)
        begin
            for (int j = 0; j < ROWS - 1; j++)
            begin
                col_reg[j] <= col_reg[j+1];
            end
            col_reg[ROWS-1] <= v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.hshift)
        begin
            vs0_reg  <= '0;
            vs1_reg  <= '0;
            vs2_reg  <= '0;
            vmin_reg <= '1;
            vmax_reg <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.m0)
            begin
                vs0_reg <= vs0_reg + VSW'(v);
            end
            if (ctl.m1)
            begin
                vs1_reg <= vs1_reg + VSW'(v);
                if (v < vmin_reg)
                begin
                    vmin_reg <= v;
                end
                if (v > vmax_reg)
                begin
                    vmax_reg <= v;
                end
            end
            if (ctl.m2)
            begin
                vs2_reg <= vs2_reg + VSW'(v);
            end
            if (ctl.mc)
            begin
                pc_reg <= v;
            end
        end
        else if (ctl.sshift)
        begin
            vs0_reg  <= vs0_in;
            vs1_reg  <= vs1_in;
            vs2_reg  <= vs2_in;
            vmin_reg <= vmin_in;
            vmax_reg <= vmax_in;
            pc_reg   <= pc_in;
        end
    end

    assign vs0_out  = vs0_reg;
    assign vs1_out  = vs1_reg;
    assign vs2_out  = vs2_reg;
    assign vmin_out = vmin_reg;
    assign vmax_out = vmax_reg;
    assign pc_out   = pc_reg;

endmodule

FILE: rtl/aelt_decide.sv
module aelt_decide #(
    parameter int VSW = 12,
    parameter int WSW = 15
) (
    input  logic                         clk,
    input  aelt_pkg::acc_ctl_t           ctl,
    input  logic [aelt_pkg::HW_W-1:0]    k,
    input  logic [aelt_pkg::ALPHA_W-1:0] alpha,
    input  logic [VSW-1:0]               vs0,
    input  logic [VSW-1:0]               vs1,
    input  logic [VSW-1:0]               vs2,
    input  logic [aelt_pkg::PIX_W-1:0]   vmin,
    input  logic [aelt_pkg::PIX_W-1:0]   vmax,
    input  logic [aelt_pkg::PIX_W-1:0]   pc,
    output logic                         background
);
    import aelt_pkg::*;

    localparam int BW = WSW + 2;
    localparam int TW = WSW + 9;

    logic [VSW-1:0]   vs [3];
    logic [2:0]       hm;
    logic [WSW-1:0]   w_reg [3][3];
    logic [PIX_W-1:0] mn_reg, mx_reg, p_reg;
    logic [3:0]       side;
    logic [7:0]       nn;
    logic [WSW-1:0]   fmin_n_reg, fmax_n_reg, p_n_reg;
    logic [WSW-1:0]   s;
    logic [WSW-1:0]   dmax, dmin;
    logic [BW-1:0]    base_reg;
    logic [TW-1:0]    t_reg;
    logic [8:0]       fg_vec;

    assign vs[0] = vs0;
    assign vs[1] = vs1;
    assign vs[2] = vs2;
    assign hm    = {ctl.h2, ctl.h1, ctl.h0};

    // window sums: row range r (from the cell) by column range c
    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    w_reg[r][c] <= '0;
                end
            end
            mn_reg <= '1;
            mx_reg <= '0;
        end
        else if (ctl.step)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (hm[c])
                    begin
                        w_reg[r][c] <= w_reg[r][c] + WSW'(vs[r]);
                    end
                end
            end
            if (ctl.h1)
            begin
                if (vmin < mn_reg)
                begin
                    mn_reg <= vmin;
                end
                if (vmax > mx_reg)
                begin
                    mx_reg <= vmax;
                end
            end
            if (ctl.hc)
            begin
                p_reg <= pc;
            end
        end
    end

    assign side = {k, 1'b1};
    assign nn   = 8'(side) * 8'(side);
    assign s    = w_reg[1][1];

    // stage 1: scale by window area
    always_ff @(posedge clk)
    begin
        fmin_n_reg <= WSW'({8'd0, mn_reg} * {8'd0, nn});
        fmax_n_reg <= WSW'({8'd0, mx_reg} * {8'd0, nn});
        p_n_reg    <= WSW'({8'd0, p_reg} * {8'd0, nn});
    end

    assign dmax = (fmax_n_reg > s) ? fmax_n_reg - s : s - fmax_n_reg;
    assign dmin = (fmin_n_reg > s) ? fmin_n_reg - s : s - fmin_n_reg;

    // stage 2: threshold base
    always_ff @(posedge clk)
    begin
        priority if (dmax > dmin)
        begin
            base_reg <= (BW'(fmin_n_reg) << 1) + BW'(s);
        end
        else if (dmax < dmin)
        begin
            base_reg <= BW'(fmin_n_reg) + (BW'(s) << 1);
        end
        else
        begin
            base_reg <= (BW'(s) << 1) + BW'(s);
        end
    end

    // stage 3: alpha scaling
    always_ff @(posedge clk)
    begin
        t_reg <= TW'(base_reg) * TW'(alpha);
    end

    genvar gr, gc;
    for (gr = 0; gr < 3; gr++)
    begin : g_row
        for (gc = 0; gc < 3; gc++)
        begin : g_col
            if (gr == 1 && gc == 1)
            begin : g_center
                assign fg_vec[gr*3+gc] = 1'b0;
            end
            else
            begin : g_nb
                logic [WSW-1:0] diff_reg;
                logic [TW-1:0]  prod_reg;

                always_ff @(posedge clk)
                begin
                    diff_reg <= (w_reg[gr][gc] > p_n_reg) ? w_reg[gr][gc] - p_n_reg
                                                          : p_n_reg - w_reg[gr][gc];
                    // x300 = 256 + 32 + 8 + 4
                    prod_reg <= (TW'(diff_reg) << 8) + (TW'(diff_reg) << 5)
                              + (TW'(diff_reg) << 3) + (TW'(diff_reg) << 2);
                end

                assign fg_vec[gr*3+gc] = (prod_reg > t_reg);
            end
        end
    end

    assign background = ~|fg_vec;

endmodule

FILE: tb/testbench.sv
module testbench;
    import aelt_pkg::*;

    localparam int RING       = 2 * DEF_MAX_HALF_WINDOW + 3;
    localparam int SETTLE     = 2 * RING + 20;
    localparam int STALL_LIMIT = 4000;
    localparam int PIXEL_GOAL  = 700;

    typedef struct {
        logic            bg;
        logic [CX_W-1:0] x;
        logic [CY_W-1:0] y;
        logic            fe;
    } decision_t;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        int               bg;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      gray_pixel;
    logic                  out_valid;
    logic                  out_stall;
    logic                  is_background;
    logic [CX_W-1:0]       center_x;
    logic [CY_W-1:0]       center_y;
    logic                  frame_end;

    adaptive_eight_landmark_threshold_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .gray_pixel(gray_pixel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_background(is_background),
        .center_x(center_x),
        .center_y(center_y),
        .frame_end(frame_end)
    );

    // mirror of the block
    logic [PIX_W-1:0] pix_ring [RING][DEF_MAX_WIDTH];
    int unsigned col_cnt, row_cnt;
    logic [HW_W-1:0]    k_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [IMGW_W-1:0]  w_reg;
    logic [IMGH_W-1:0]  h_reg;

    decision_t decisions_due[$];
    int  errors;
    int  pixels_sent;
    int  decisions_seen;
    int  fg_seen;
    int  idle_cycles;
    int  pinned_bg;
    bit  quiet;
    bit  took_result;
    int  out_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint window_total(int cx, int cy, int k,
                                            output int lo, output int hi);
        longint s;
        int v;
        s  = 0;
        lo = 255;
        hi = 0;
        for (int j = cy - k; j <= cy + k; j++)
        begin
            for (int i = cx - k; i <= cx + k; i++)
            begin
                v = int'(pix_ring[j % RING][i]);
                s += v;
                if (v < lo) lo = v;
                if (v > hi) hi = v;
            end
        end
        return s;
    endfunction

    function automatic longint gap(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic classify_pixel(input logic [PIX_W-1:0] p);
        int k, w, h, c, r, x, y, mn, mx, dmn, dmx;
        longint nn, a, s, t, pn, ls;
        bit fg;
        decision_t d;
        int dx [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
        int dy [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
        k = (k_reg < 1) ? 1 : (k_reg > DEF_MAX_HALF_WINDOW) ? DEF_MAX_HALF_WINDOW : int'(k_reg);
        w = (w_reg < 1) ? 1 : (w_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w_reg);
        h = (h_reg < 1) ? 1 : (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_reg);
        c = col_cnt;
        r = row_cnt;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        pix_ring[r % RING][c] = p;
        if (r >= 2 * k + 2 && c >= 2 * k + 2)
        begin
            x  = c - k - 1;
            y  = r - k - 1;
            nn = (2 * k + 1) * (2 * k + 1);
            a  = longint'(alpha_reg);
            s  = window_total(x, y, k, mn, mx);
            pn = longint'(pix_ring[y % RING][x]) * nn;
            if (gap(mx * nn, s) > gap(mn * nn, s))
                t = a * (2 * mn * nn + s);
            else if (gap(mx * nn, s) < gap(mn * nn, s))
                t = a * (mn * nn + 2 * s);
            else
                t = 3 * a * s;
            fg = 1'b0;
            for (int l = 0; l < 8 && !fg; l++)
            begin
                ls = window_total(x + dx[l], y + dy[l], k, dmn, dmx);
                if (300 * gap(ls, pn) > t) fg = 1'b1;
            end
            d.bg = !fg;
            if (pinned_bg >= 0) d.bg = pinned_bg[0];
            d.x  = CX_W'(x);
            d.y  = CY_W'(y);
            d.fe = (r == h - 1 && c == w - 1);
            decisions_due.push_back(d);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endtask

    always @(posedge clk)
    begin
        decision_t d;
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_HALF_WINDOW: k_reg = cfg_data[HW_W-1:0];
                    CFG_ALPHA:       alpha_reg = cfg_data[ALPHA_W-1:0];
                    CFG_WIDTH:       w_reg = cfg_data[IMGW_W-1:0];
                    CFG_HEIGHT:      h_reg = cfg_data[IMGH_W-1:0];
                endcase
            end
            if (in_valid && !in_stall)
            begin
                idle_cycles = 0;
                classify_pixel(gray_pixel);
            end
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                took_result = 1'b1;
                decisions_seen++;
                if (!is_background) fg_seen++;
                if (decisions_due.size() == 0)
                begin
                    $error("unexpected result transaction at x=%0d y=%0d", center_x, center_y);
                    errors++;
                end
                else
                begin
                    d = decisions_due.pop_front();
                    if (is_background !== d.bg)
                    begin
                        $error("is_background: expected %0d, got %0d", d.bg, is_background);
                        errors++;
                    end
                    if (center_x !== d.x)
                    begin
                        $error("center_x: expected %0d, got %0d", d.x, center_x);
                        errors++;
                    end
                    if (center_y !== d.y)
                    begin
                        $error("center_y: expected %0d, got %0d", d.y, center_y);
                        errors++;
                    end
                    if (frame_end !== d.fe)
                    begin
                        $error("frame_end: expected %0d, got %0d", d.fe, frame_end);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (took_result)
        begin
            took_result = 1'b0;
            out_hold = quiet ? 0 : $urandom_range(0, 10);
        end
        out_stall <= (out_hold > 0);
        if (out_hold > 0) out_hold--;
    end

    task automatic write_reg(input cfg_index_t idx, input int unsigned val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] p, input int bg);
        int wait_n;
        wait_n = quiet ? 0 : $urandom_range(0, 10);
        if (wait_n > 0)
        begin
            in_valid <= 1'b0;
            repeat (wait_n) @(negedge clk);
        end
        pinned_bg = bg;
        in_valid   <= 1'b1;
        gray_pixel <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        pinned_bg = -1;
        while (decisions_due.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic configure(input int k, input int alpha, input int w, input int h);
        write_reg(CFG_HALF_WINDOW, k);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    function automatic logic [PIX_W-1:0] scene_pixel(int style, int i, int j, int base);
        int v;
        case (style)
            0: v = $urandom_range(0, 255);
            1: v = base + $urandom_range(0, 6) - 3;
            2: v = ((i % 7) < 3 && (j % 5) < 2) ? base / 4 : base + $urandom_range(0, 4);
            default: v = (i * 17 + j * 9 + base) % 256;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
    endfunction

    task automatic send_frame(input int w, input int h, input int style);
        int base;
        base  = $urandom_range(0, 255);
        quiet = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++)
                send_pixel(scene_pixel(style, i, j, base), -1);
        quiet = 1'b0;
        drain();
    endtask

    directed_row_t flat_frame [25];

    initial
    begin
        int k, w, h;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_HALF_WINDOW;
        cfg_data   = '0;
        in_valid   = 1'b0;
        gray_pixel = '0;
        out_stall  = 1'b0;
        errors = 0;
        pixels_sent = 0;
        decisions_seen = 0;
        fg_seen = 0;
        idle_cycles = 0;
        pinned_bg = -1;
        quiet = 1'b0;
        took_result = 1'b0;
        out_hold = 0;
        col_cnt = 0;
        row_cnt = 0;
        k_reg = RST_HALF_WINDOW;
        alpha_reg = RST_ALPHA;
        w_reg = RST_WIDTH;
        h_reg = RST_HEIGHT;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // 5x5 flat white frame, K=1: one center, uniform windows -> background
        for (int n = 0; n < 25; n++) flat_frame[n] = '{8'd255, (n == 24) ? 1 : -1};
        configure(1, 100, 5, 5);
        foreach (flat_frame[n]) send_pixel(flat_frame[n].pixel, flat_frame[n].bg);
        drain();

        // out-of-range writes, then K above the maximum with full alpha
        configure(0, 0, 0, 8191);
        configure(7, 127, 2047, 13);
        configure(7, 127, 13, 13);
        send_frame(13, 13, 3);
        configure(5, 10, 13, 13);
        send_frame(13, 13, 2);

        while (pixels_sent < PIXEL_GOAL)
        begin
            k = $urandom_range(0, 7);
            if ($urandom_range(0, 7) == 0)
            begin
                w = $urandom_range(0, 12);
                h = $urandom_range(0, 12);
            end
            else
            begin
                w = $urandom_range(13, 24);
                h = $urandom_range(13, 20);
            end
            configure(k, $urandom_range(0, 127), w, h);
            send_frame((w < 1) ? 1 : w, (h < 1) ? 1 : h, $urandom_range(0, 3));
        end

        $display("covered %0d pixels and %0d decisions (%0d foreground)",
                 pixels_sent, decisions_seen, fg_seen);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
